FILE: sv/modexp_pkg.sv
package modexp_pkg;

  // operand width of base, exponent, modulus and result
  localparam int unsigned OPERAND_BITS = 31;
  localparam int unsigned CNT_BITS = $clog2(OPERAND_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(OPERAND_BITS - 1);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a new item
    logic red;    // one bit step of the base reduction
    logic mul;    // one bit step of square and multiply
    logic emit;   // move result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;   // new item is answered without iterating
    logic cnt_last;  // last bit step of the current pass
    logic e_last;    // no exponent bits left after this pass
    logic out_busy;  // output register holds an item not yet taken
  } sts_t;

  // one interleaved step: (2*p + (bit ? y : 0)) mod m, with p < m and y <= m
  function automatic operand_t mod_step(operand_t p, logic bit_i, operand_t y, operand_t m);
    logic [OPERAND_BITS:0] t;
    logic [OPERAND_BITS:0] u;
    t = {p, 1'b0};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    u = t + (bit_i ? {1'b0, y} : '0);
    if (u >= {1'b0, m}) begin
      u = u - {1'b0, m};
    end
    return u[OPERAND_BITS-1:0];
  endfunction

endpackage

FILE: sv/modexp_dp.sv
module modexp_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  modexp_pkg::cmd_t       cmd_i,
  output modexp_pkg::sts_t       sts_o,
  input  logic                   func_i,
  input  modexp_pkg::operand_t   base_i,
  input  modexp_pkg::operand_t   exponent_i,
  input  modexp_pkg::operand_t   modulus_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output modexp_pkg::operand_t   result_o
);
  import modexp_pkg::*;

  operand_t m_q, e_q, b_q, acc_q, ps_q, pm_q, sh_q, res_q;
  operand_t m_d, e_d, b_d, acc_d, ps_d, pm_d, sh_d, res_d;
  cnt_t     cnt_q, cnt_d;
  logic     out_valid_q, out_valid_d;

  operand_t e_eff;
  operand_t special_val;
  logic     special;
  operand_t ps_step, pm_step, ps_y;

  // exponent in use and items answered without iterating
  always_comb begin
    e_eff = func_i ? (modulus_i - operand_t'(2)) : exponent_i;
    special = 1'b0;
    special_val = '0;
    if (modulus_i == '0 || (func_i && modulus_i == operand_t'(1))) begin
      special = 1'b1;
    end else if (e_eff == '0) begin
      special = 1'b1;
      special_val = operand_t'(1);
    end
  end

  // reduction pass adds the base bits one by one, power pass multiplies by b
  assign ps_y    = cmd_i.red ? operand_t'(1) : b_q;
  assign ps_step = mod_step(ps_q, sh_q[OPERAND_BITS-1], ps_y, m_q);
  assign pm_step = mod_step(pm_q, sh_q[OPERAND_BITS-1], acc_q, m_q);

  always_comb begin
    m_d = m_q;
    e_d = e_q;
    b_d = b_q;
    acc_d = acc_q;
    ps_d = ps_q;
    pm_d = pm_q;
    sh_d = sh_q;
    cnt_d = cnt_q;
    res_d = res_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      m_d = modulus_i;
      e_d = e_eff;
      sh_d = base_i;
      ps_d = '0;
      pm_d = '0;
      cnt_d = '0;
      if (special) begin
        acc_d = special_val;
      end else begin
        acc_d = (modulus_i == operand_t'(1)) ? '0 : operand_t'(1);
      end
    end
    if (cmd_i.red || cmd_i.mul) begin
      ps_d = ps_step;
      pm_d = pm_step;
      sh_d = {sh_q[OPERAND_BITS-2:0], 1'b0};
      cnt_d = cnt_q + cnt_t'(1);
      if (cnt_q == CNT_LAST) begin
        b_d = ps_step;
        sh_d = ps_step;
        ps_d = '0;
        pm_d = '0;
        cnt_d = '0;
        if (cmd_i.mul) begin
          if (e_q[0]) begin
            acc_d = pm_step;
          end
          e_d = e_q >> 1;
        end
      end
    end
    if (cmd_i.emit) begin
      res_d = acc_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    e_q <= e_d;
    b_q <= b_d;
    acc_q <= acc_d;
    ps_q <= ps_d;
    pm_q <= pm_d;
    sh_q <= sh_d;
    res_q <= res_d;
  end

  assign sts_o.special  = special;
  assign sts_o.cnt_last = (cnt_q == CNT_LAST);
  assign sts_o.e_last   = ((e_q >> 1) == '0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

`ifndef SYNTHESIS
  a_residues_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> (ps_q < m_q && pm_q < m_q && b_q < m_q && acc_q < m_q))
    else $error("residue not below modulus during power pass");
  a_load_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> cnt_q == '0)
    else $error("bit counter not cleared on new item");
`endif

endmodule

FILE: sv/modexp_ctrl.sv
module modexp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  modexp_pkg::sts_t sts_i,
  output modexp_pkg::cmd_t cmd_o
);
  import modexp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RED  = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = sts_i.special ? S_DONE : S_RED;
        end
      end
      S_RED: begin
        cmd_o.red = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.cnt_last && sts_i.e_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");
  a_red_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED && sts_i.cnt_last) |=> state_q == S_MUL)
    else $error("reduction pass did not hand over to power pass");
`endif

endmodule

FILE: sv/modular_exponentiation.sv
// channel | valid      | ready       | payload
// in      | in_valid_i | in_ready_o  | func_i, base_i, exponent_i, modulus_i
// out     | out_valid_o| out_ready_i | result_o
//
// one item at a time; an item with L significant exponent bits (exponent, or
// modulus minus two in inverse mode) runs one base reduction pass, then one square and
// multiply pass per exponent bit, each paced by the one-bit-per-cycle modular multiply step
// items answered directly (zero modulus, zero exponent, inverse below two) skip the passes
// reset is asynchronous, active low, and clears the controller, bit counter and output valid
// a waiting result does not block the next item; a finished item waits for the slot
module modular_exponentiation (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  modexp_pkg::operand_t base_i,
  input  modexp_pkg::operand_t exponent_i,
  input  modexp_pkg::operand_t modulus_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output modexp_pkg::operand_t result_o
);
  import modexp_pkg::*;

  // commands and status between sequencer and arithmetic
  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, base reduction pass, square and multiply passes, result hand-off
  modexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: two interleaved modular multiply lanes sharing the multiplier bits,
  // one for b*b and one for acc*b, plus the output register
  modexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .modulus_i   (modulus_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .result_o    (result_o)
  );

endmodule

FILE: tb/modexp_residue_check.sv
`timescale 1ns / 1ps

module modexp_residue_check
  import modexp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  logic     func_i,
  input  operand_t base_i,
  input  operand_t exponent_i,
  input  operand_t modulus_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  operand_t result_i,
  output int       fail_count_o,
  output int       pending_o
);

  typedef struct {
    logic     func;
    operand_t base;
    operand_t exponent;
    operand_t modulus;
    operand_t residue;
  } residue_entry_t;

  residue_entry_t expected_residues[$];
  residue_entry_t accepted;
  residue_entry_t oldest;
  int             mismatches = 0;

  assign fail_count_o = mismatches;

  // square and multiply on 64-bit words, operands stay below 2^31
  function automatic operand_t predict_residue(logic func, operand_t b, operand_t e,
                                               operand_t m);
    bit [63:0] bw;
    bit [63:0] ew;
    bit [63:0] mw;
    bit [63:0] acc;
    bw = 64'(b);
    ew = 64'(e);
    mw = 64'(m);
    if (mw == 0) return '0;
    if (func) begin
      if (mw < 2) return '0;
      ew = mw - 2;
    end
    if (ew == 0) return operand_t'(1);
    bw  = bw % mw;
    acc = 1 % mw;
    while (ew != 0) begin
      if (ew[0]) acc = (acc * bw) % mw;
      bw = (bw * bw) % mw;
      ew = ew >> 1;
    end
    return operand_t'(acc);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // results first: a result never comes from an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_residues.size() == 0) begin
          report_mismatch($sformatf("result %0h with no item outstanding", result_i));
        end else begin
          oldest = expected_residues.pop_front();
          if (result_i !== oldest.residue) begin
            report_mismatch($sformatf("func %0d base %0h exp %0h mod %0h: got %0h want %0h",
                                      oldest.func, oldest.base, oldest.exponent,
                                      oldest.modulus, result_i, oldest.residue));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        accepted.func     = func_i;
        accepted.base     = base_i;
        accepted.exponent = exponent_i;
        accepted.modulus  = modulus_i;
        accepted.residue  = predict_residue(func_i, base_i, exponent_i, modulus_i);
        expected_residues.push_back(accepted);
      end
    end
    pending_o <= expected_residues.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import modexp_pkg::*;

  // cycles with no item moving on either channel before the run is abandoned;
  // it has to cover the slowest item, plus receiver stalls and sender gaps
  localparam int unsigned QUIET_LIMIT = 8000;
  // idle wait after the last result, long enough to cover the slowest item
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam operand_t OPERAND_MAX = '1;

  // receiver behavior, picked anew for each random span of cycles
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_STALLS,
    RX_PERIODIC
  } rx_mode_e;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  logic     func;
  operand_t base;
  operand_t exponent;
  operand_t modulus;
  logic     out_valid;
  logic     out_ready;
  operand_t result;

  int          fail_count;
  int          pending;
  int unsigned quiet_cycles = 0;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modular_exponentiation dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .func_i     (func),
    .base_i     (base),
    .exponent_i (exponent),
    .modulus_i  (modulus),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .result_o   (result)
  );

  // predicts every accepted item and compares results in order
  modexp_residue_check u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (func),
    .base_i      (base),
    .exponent_i  (exponent),
    .modulus_i   (modulus),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .result_i    (result),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // value with exactly n significant bits, zero for n of zero
  function automatic operand_t rand_bits(int unsigned n);
    int unsigned v;
    if (n == 0) return '0;
    v = $urandom & ((32'h1 << n) - 1);
    v = v | (32'h1 << (n - 1));
    return operand_t'(v);
  endfunction

  // small prime modulus, so inverse items are real inverses and stay short
  function automatic operand_t random_prime();
    int unsigned n;
    bit          found;
    found = 1'b0;
    n     = 3;
    while (!found) begin
      n     = $urandom_range(3, 4093);
      found = 1'b1;
      for (int unsigned d = 2; d * d <= n; d++) begin
        if (n % d == 0) found = 1'b0;
      end
    end
    return operand_t'(n);
  endfunction

  // present one item at the falling edge and hold it until it is taken;
  // valid stays high so the next call can follow back to back
  task automatic send_item(logic f, operand_t b, operand_t e, operand_t m);
    @(negedge clk);
    in_valid <= 1'b1;
    func     <= f;
    base     <= b;
    exponent <= e;
    modulus  <= m;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // hold the sender off until every outstanding item has its result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // watchdog: count edges at which nothing is accepted on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("** modular_exponentiation: FAILED **");
    $finish;
  end

  // receiver: each span of cycles picks its own ready pattern
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(50, 400);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          RX_ALWAYS: begin
            out_ready <= 1'b1;
          end
          RX_COIN: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          RX_STALLS: begin
            // mostly ready, with an occasional long stall
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
              if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(1, 40);
            end
          end
          default: begin
            out_ready <= (k % 7) < 4;
          end
        endcase
      end
    end
  end

  // sender and verdict
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    logic        f;
    operand_t    b;
    operand_t    e;
    operand_t    m;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    func     <= 1'b0;
    base     <= '0;
    exponent <= '0;
    modulus  <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_cycles(3);

    // directed corners
    // zero exponent gives one, even with a unit modulus
    send_item(1'b0, 31'd5, 31'd0, 31'd1);
    send_item(1'b0, OPERAND_MAX, 31'd0, OPERAND_MAX);
    // unit modulus with a nonzero exponent gives zero
    send_item(1'b0, 31'd7, 31'd9, 31'd1);
    send_item(1'b0, 31'd0, 31'd5, 31'd13);
    send_item(1'b0, 31'd3, 31'd1, 31'd1000);
    // base above the modulus must be reduced first
    send_item(1'b0, 31'd1000, 31'd3, 31'd7);
    send_item(1'b0, 31'd3, 31'd5, 31'd2);
    send_item(1'b0, OPERAND_MAX, 31'd2, OPERAND_MAX - 1);
    send_item(1'b0, 31'd2, OPERAND_MAX, 31'd1000003);
    // all fields at their largest
    send_item(1'b0, OPERAND_MAX, OPERAND_MAX, OPERAND_MAX);
    send_item(1'b0, 31'h2aaaaaaa, 31'h55555555, 31'h40000000);
    // inverse below two gives zero, inverse mod two gives one
    send_item(1'b1, 31'd9, 31'd0, 31'd1);
    send_item(1'b1, 31'd9, OPERAND_MAX, 31'd2);
    send_item(1'b1, 31'd2, 31'd0, 31'd3);
    send_item(1'b1, 31'd10, 31'd77, 31'd11);
    send_item(1'b1, 31'd12345, 31'd0, OPERAND_MAX);
    // non-prime modulus in inverse mode is still just a power
    send_item(1'b1, 31'd4, 31'd0, 31'd15);
    // base a multiple of the modulus has no inverse
    send_item(1'b1, 31'd34, 31'd3, 31'd17);
    send_item(1'b1, OPERAND_MAX, OPERAND_MAX, 31'd4093);
    wait_drained();

    // random bursts; most exponents short to keep items fast
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      for (int unsigned i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        f = ($urandom_range(0, 3) == 0);
        if (!f) begin
          pick = $urandom_range(0, 99);
          if (pick < 5) m = 31'd1;
          else if (pick < 10) m = 31'd2;
          else m = rand_bits($urandom_range(2, 31));
          if ($urandom_range(0, 99) < 85) e = rand_bits($urandom_range(0, 8));
          else e = rand_bits($urandom_range(9, 31));
        end else begin
          // inverse cost follows the modulus length, so large ones are rare
          pick = $urandom_range(0, 99);
          if (pick < 70) m = random_prime();
          else if (pick < 85) m = operand_t'($urandom_range(1, 300));
          else if (pick < 90) m = OPERAND_MAX;
          else m = rand_bits(31) | 31'd1;
          e = rand_bits($urandom_range(0, 31));  // ignored in inverse mode
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) b = '0;
        else if (pick < 10) b = operand_t'(m * $urandom_range(1, 3));
        else if (pick < 55) b = rand_bits($urandom_range(0, 31));
        else b = operand_t'($urandom % m);
        send_item(f, b, e, m);
        sent++;
        // pause the sender now and then until the block is empty
        if (sent % 300 == 0) wait_drained();
      end
      idle_cycles(gap);
    end

    wait_drained();
    idle_cycles(DRAIN_CYCLES);

    if (fail_count == 0 && pending == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

endmodule
